[rtl/wua_pkg.sv]
// Shared types and constants for the 96-bit unsigned arithmetic unit.
`timescale 1ns / 1ps

package wua_pkg;

  localparam int MAG_BITS  = 96;
  localparam int LOW_BITS  = 64;
  localparam int HIGH_BITS = MAG_BITS - LOW_BITS;
  localparam int CNT_BITS  = $clog2(MAG_BITS);
  localparam int MODE_BITS = 3;

  localparam logic [MODE_BITS-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_X10 = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_DIV = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_CMP = 3'd4;

  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(MAG_BITS - 1);

  typedef logic [MAG_BITS-1:0] mag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_div;
  } sts_t;

endpackage

[rtl/wua_dpath.sv]
// Datapath: operand registers, restoring divider step, combinational ops, result registers.
`timescale 1ns / 1ps

module wua_dpath (
  input  logic                               clk,
  input  logic [wua_pkg::MODE_BITS-1:0]      in_mode,
  input  logic [wua_pkg::LOW_BITS-1:0]       in_a_low,
  input  logic [wua_pkg::HIGH_BITS-1:0]      in_a_high,
  input  logic [wua_pkg::LOW_BITS-1:0]       in_b_low,
  input  logic [wua_pkg::HIGH_BITS-1:0]      in_b_high,
  input  wua_pkg::cmd_t                      cmd,
  output wua_pkg::sts_t                      sts,
  output logic [wua_pkg::LOW_BITS-1:0]       out_result_low,
  output logic [wua_pkg::HIGH_BITS-1:0]      out_result_high,
  output logic [wua_pkg::LOW_BITS-1:0]       out_remainder_low,
  output logic [wua_pkg::HIGH_BITS-1:0]      out_remainder_high,
  output logic                               out_carry_or_borrow,
  output logic                               out_a_greater,
  output logic                               out_a_equal,
  output logic                               out_divide_by_zero
);

  logic [wua_pkg::MODE_BITS-1:0] mode_r;
  wua_pkg::mag_t                 a_r;
  wua_pkg::mag_t                 b_r;
  wua_pkg::mag_t                 rem_r;

  wua_pkg::mag_t                 res_r,  res_nxt;
  wua_pkg::mag_t                 remo_r, remo_nxt;
  logic                          cy_r,   cy_nxt;
  logic                          gt_r,   gt_nxt;
  logic                          eq_r,   eq_nxt;
  logic                          dz_r,   dz_nxt;

  wua_pkg::mag_t                 in_a;
  wua_pkg::mag_t                 in_b;
  wua_pkg::mag_t                 rem_sh;
  logic [wua_pkg::MAG_BITS:0]    diff;
  logic                          take;
  logic [wua_pkg::MAG_BITS:0]    sum;
  logic [wua_pkg::MAG_BITS:0]    dif;
  logic [wua_pkg::MAG_BITS+3:0]  prod;
  logic                          b_zero;

  assign in_a = {in_a_high, in_a_low};
  assign in_b = {in_b_high, in_b_low};
  assign sts.start_div = (in_mode == wua_pkg::MODE_DIV) && (in_b != '0);

  // One restoring division step: shift the next dividend bit into the
  // partial remainder and subtract the divisor when it fits.
  assign rem_sh = {rem_r[wua_pkg::MAG_BITS-2:0], a_r[wua_pkg::MAG_BITS-1]};
  assign diff   = {rem_r[wua_pkg::MAG_BITS-1], rem_sh} - {1'b0, b_r};
  assign take   = ~diff[wua_pkg::MAG_BITS];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      a_r    <= in_a;
      b_r    <= in_b;
      rem_r  <= '0;
    end else if (cmd.step) begin
      rem_r <= take ? diff[wua_pkg::MAG_BITS-1:0] : rem_sh;
      a_r   <= {a_r[wua_pkg::MAG_BITS-2:0], take};
    end
  end

  assign sum    = {1'b0, a_r} + {1'b0, b_r};
  assign dif    = {1'b0, a_r} - {1'b0, b_r};
  assign prod   = {1'b0, a_r, 3'b000} + {3'b000, a_r, 1'b0};
  assign b_zero = (b_r == '0);

  always_comb begin
    res_nxt  = '0;
    remo_nxt = '0;
    cy_nxt   = 1'b0;
    gt_nxt   = 1'b0;
    eq_nxt   = 1'b0;
    dz_nxt   = 1'b0;
    case (mode_r)
      wua_pkg::MODE_ADD: begin
        res_nxt = sum[wua_pkg::MAG_BITS-1:0];
        cy_nxt  = sum[wua_pkg::MAG_BITS];
      end
      wua_pkg::MODE_SUB: begin
        res_nxt = dif[wua_pkg::MAG_BITS-1:0];
        cy_nxt  = dif[wua_pkg::MAG_BITS];
      end
      wua_pkg::MODE_X10: begin
        res_nxt = prod[wua_pkg::MAG_BITS-1:0];
        cy_nxt  = |prod[wua_pkg::MAG_BITS+3:wua_pkg::MAG_BITS];
      end
      wua_pkg::MODE_DIV: begin
        if (b_zero) begin
          dz_nxt = 1'b1;
        end else begin
          res_nxt  = a_r;
          remo_nxt = rem_r;
        end
      end
      wua_pkg::MODE_CMP: begin
        gt_nxt = ~dif[wua_pkg::MAG_BITS] && (a_r != b_r);
        eq_nxt = (a_r == b_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r  <= res_nxt;
      remo_r <= remo_nxt;
      cy_r   <= cy_nxt;
      gt_r   <= gt_nxt;
      eq_r   <= eq_nxt;
      dz_r   <= dz_nxt;
    end
  end

  assign out_result_low      = res_r[wua_pkg::LOW_BITS-1:0];
  assign out_result_high     = res_r[wua_pkg::MAG_BITS-1:wua_pkg::LOW_BITS];
  assign out_remainder_low   = remo_r[wua_pkg::LOW_BITS-1:0];
  assign out_remainder_high  = remo_r[wua_pkg::MAG_BITS-1:wua_pkg::LOW_BITS];
  assign out_carry_or_borrow = cy_r;
  assign out_a_greater       = gt_r;
  assign out_a_equal         = eq_r;
  assign out_divide_by_zero  = dz_r;

endmodule

[rtl/wua_ctrl.sv]
// Controller: sequences item intake, division steps and the result register.
`timescale 1ns / 1ps

module wua_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  wua_pkg::sts_t  sts,
  output wua_pkg::cmd_t  cmd
);

  wua_pkg::state_t               state_r, state_nxt;
  logic [wua_pkg::CNT_BITS-1:0]  cnt_r,   cnt_nxt;
  logic                          ovld_r,  ovld_nxt;
  logic                          slot_free;

  assign slot_free = ~ovld_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wua_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.start_div ? wua_pkg::ST_DIV : wua_pkg::ST_HOLD;
        end
      end
      wua_pkg::ST_DIV: begin
        if (cnt_r == wua_pkg::LAST_STEP) begin
          state_nxt = wua_pkg::ST_HOLD;
        end
      end
      wua_pkg::ST_HOLD: begin
        if (slot_free) begin
          state_nxt = wua_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wua_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.out_load = 1'b0;
    cnt_nxt      = cnt_r;
    case (state_r)
      wua_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cnt_nxt  = '0;
      end
      wua_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
      end
      wua_pkg::ST_HOLD: begin
        cmd.out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (cmd.out_load) begin
      ovld_nxt = 1'b1;
    end else if (out_ready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wua_pkg::ST_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_valid = ovld_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!ovld_r || out_ready))
    else $error("result register loaded while a result is still pending");

  a_div_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.start_div) |=> (!in_ready && cmd.step))
    else $error("division item did not start stepping");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (cnt_r <= wua_pkg::LAST_STEP))
    else $error("division step count out of range");

  a_load_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && (cmd.step || cmd.out_load)))
    else $error("operand load overlaps other datapath commands");

endmodule

[rtl/wide_unsigned_alu_96.sv]
// Top level of the 96-bit unsigned add, subtract, times-ten, divide and compare unit.
`timescale 1ns / 1ps

// The unit takes one item at a time: an operation code and two 96-bit
// unsigned operands, each given as a 64-bit low half and a 32-bit high half.
// Add, subtract, multiply-by-ten and compare are computed in one pass: the
// operands are registered at intake, and the result goes into the output
// register once it is free, after which a new item is taken. Divide runs a
// restoring shift-subtract divider that produces one quotient bit per clock,
// so a divide item passes through intake, all its divider steps and the
// result register. A divide by zero skips the divider and finishes like a
// single-pass item, with the divide_by_zero flag set and zero quotient and
// remainder. Results go into an output register, so the next item can be
// accepted and worked on while the previous result still waits for
// out_ready. Codes outside the five operations give an all-zero result item.

module wide_unsigned_alu_96 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [wua_pkg::MODE_BITS-1:0]      in_mode,
  input  logic [wua_pkg::LOW_BITS-1:0]       in_a_low,
  input  logic [wua_pkg::HIGH_BITS-1:0]      in_a_high,
  input  logic [wua_pkg::LOW_BITS-1:0]       in_b_low,
  input  logic [wua_pkg::HIGH_BITS-1:0]      in_b_high,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wua_pkg::LOW_BITS-1:0]       out_result_low,
  output logic [wua_pkg::HIGH_BITS-1:0]      out_result_high,
  output logic [wua_pkg::LOW_BITS-1:0]       out_remainder_low,
  output logic [wua_pkg::HIGH_BITS-1:0]      out_remainder_high,
  output logic                               out_carry_or_borrow,
  output logic                               out_a_greater,
  output logic                               out_a_equal,
  output logic                               out_divide_by_zero
);

  // Commands flow from the controller to the datapath; the datapath reports
  // back whether a freshly presented item needs the divider.
  wua_pkg::cmd_t cmd;
  wua_pkg::sts_t sts;

  wua_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the operands, the partial remainder and quotient
  // during division, and the registered result item.
  wua_dpath u_dpath (
    .clk                 (clk),
    .in_mode             (in_mode),
    .in_a_low            (in_a_low),
    .in_a_high           (in_a_high),
    .in_b_low            (in_b_low),
    .in_b_high           (in_b_high),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_result_low      (out_result_low),
    .out_result_high     (out_result_high),
    .out_remainder_low   (out_remainder_low),
    .out_remainder_high  (out_remainder_high),
    .out_carry_or_borrow (out_carry_or_borrow),
    .out_a_greater       (out_a_greater),
    .out_a_equal         (out_a_equal),
    .out_divide_by_zero  (out_divide_by_zero)
  );

endmodule
